@@ src/h2r_pkg.sv @@
package h2r_pkg;

  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [33:0] HALF_Q16 = 34'd32768;
  localparam logic [18:0] HUE_MULT = 19'd6;

  // Sector codes of the hue circle
  localparam logic [2:0] SECTOR_RED_YEL  = 3'd0;
  localparam logic [2:0] SECTOR_YEL_GRN  = 3'd1;
  localparam logic [2:0] SECTOR_GRN_CYAN = 3'd2;
  localparam logic [2:0] SECTOR_CYAN_BLU = 3'd3;
  localparam logic [2:0] SECTOR_BLU_MAG  = 3'd4;

  // After hue split and saturation clamp
  typedef struct packed {
    logic [16:0] sat;
    logic [16:0] val;
    logic [2:0]  sector;
    logic [15:0] frac;
  } h2r_split_t;

  // After saturation products: the complements 1-S, 1-S*f, 1-S*(1-f)
  typedef struct packed {
    logic [16:0] cmp_p;
    logic [16:0] cmp_q;
    logic [16:0] cmp_t;
    logic [16:0] val;
    logic [2:0]  sector;
  } h2r_coef_t;

  // After brightness scaling
  typedef struct packed {
    logic [16:0] p;
    logic [16:0] q;
    logic [16:0] t;
    logic [16:0] val;
    logic [2:0]  sector;
  } h2r_comp_t;

  // Q16 product rounded half up; every caller keeps the result within 17 bits
  function automatic logic [16:0] mul_q16(input logic [16:0] a, input logic [16:0] b);
    logic [33:0] prod;
    prod = ({17'd0, a} * {17'd0, b}) + HALF_Q16;
    return prod[32:16];
  endfunction

endpackage

@@ src/h2r_split.sv @@
module h2r_split
  import h2r_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        in_valid,
  input  logic [15:0] hue,
  input  logic [16:0] saturation,
  input  logic [16:0] brightness,
  output logic        out_valid,
  output h2r_split_t  out_data
);

  h2r_split_t  split_next;
  logic [18:0] h6;

  always_comb begin
    h6                = {3'd0, hue} * HUE_MULT;
    split_next.sat    = (saturation > ONE_Q16) ? ONE_Q16 : saturation;
    split_next.val    = brightness;
    split_next.sector = h6[18:16];
    split_next.frac   = h6[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_data <= split_next;
    end
  end

endmodule

@@ src/h2r_coef.sv @@
module h2r_coef
  import h2r_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic       in_valid,
  input  h2r_split_t in_data,
  output logic       out_valid,
  output h2r_coef_t  out_data
);

  h2r_coef_t   coef_next;
  logic [16:0] frac_cmp;

  always_comb begin
    frac_cmp         = ONE_Q16 - {1'b0, in_data.frac};
    coef_next.cmp_p  = ONE_Q16 - in_data.sat;
    coef_next.cmp_q  = ONE_Q16 - mul_q16(in_data.sat, {1'b0, in_data.frac});
    coef_next.cmp_t  = ONE_Q16 - mul_q16(in_data.sat, frac_cmp);
    coef_next.val    = in_data.val;
    coef_next.sector = in_data.sector;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_data <= coef_next;
    end
  end

endmodule

@@ src/h2r_scale.sv @@
module h2r_scale
  import h2r_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  logic      in_valid,
  input  h2r_coef_t in_data,
  output logic      out_valid,
  output h2r_comp_t out_data
);

  h2r_comp_t comp_next;

  always_comb begin
    comp_next.p      = mul_q16(in_data.val, in_data.cmp_p);
    comp_next.q      = mul_q16(in_data.val, in_data.cmp_q);
    comp_next.t      = mul_q16(in_data.val, in_data.cmp_t);
    comp_next.val    = in_data.val;
    comp_next.sector = in_data.sector;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_data <= comp_next;
    end
  end

endmodule

@@ src/hsv_to_rgb_converter.sv @@
// Channel | Handshake           | Payload
// --------+---------------------+-----------------------------------------
// input   | in_valid / in_stall | hue[15:0], saturation[16:0], brightness[16:0]
// output  | out_valid/out_stall | red[16:0], green[16:0], blue[16:0]
//
// Four register stages: hue split and clamp, saturation products,
// brightness products, sector select into the output register.
// One beat per cycle while out_stall is low; a beat passes the split, coef, scale and output registers.
// Reset (rst, synchronous) clears the stage valid bits only.
// A stall on the output holds only the stages that are full behind it; empty
// stages keep filling, so in_stall rises once all four stages hold a beat.
module hsv_to_rgb_converter
  import h2r_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] hue,
  input  logic [16:0] saturation,
  input  logic [16:0] brightness,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] red,
  output logic [16:0] green,
  output logic [16:0] blue
);

  h2r_split_t  split_data;
  h2r_coef_t   coef_data;
  h2r_comp_t   comp_data;
  logic        split_valid;
  logic        coef_valid;
  logic        comp_valid;
  logic        adv_split;
  logic        adv_coef;
  logic        adv_comp;
  logic        adv_out;
  logic [16:0] red_next;
  logic [16:0] green_next;
  logic [16:0] blue_next;

  // Advance a stage when it is empty or its beat moves on
  assign adv_out   = !out_valid || !out_stall;
  assign adv_comp  = !comp_valid || adv_out;
  assign adv_coef  = !coef_valid || adv_comp;
  assign adv_split = !split_valid || adv_coef;
  assign in_stall  = !adv_split;

  h2r_split u_split (
    .clk        (clk),
    .rst        (rst),
    .advance    (adv_split),
    .in_valid   (in_valid),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (split_valid),
    .out_data   (split_data)
  );

  h2r_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .advance   (adv_coef),
    .in_valid  (split_valid),
    .in_data   (split_data),
    .out_valid (coef_valid),
    .out_data  (coef_data)
  );

  h2r_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .advance   (adv_comp),
    .in_valid  (coef_valid),
    .in_data   (coef_data),
    .out_valid (comp_valid),
    .out_data  (comp_data)
  );

  always_comb begin
    case (comp_data.sector)
      SECTOR_RED_YEL: begin
        red_next = comp_data.val; green_next = comp_data.t;   blue_next = comp_data.p;
      end
      SECTOR_YEL_GRN: begin
        red_next = comp_data.q;   green_next = comp_data.val; blue_next = comp_data.p;
      end
      SECTOR_GRN_CYAN: begin
        red_next = comp_data.p;   green_next = comp_data.val; blue_next = comp_data.t;
      end
      SECTOR_CYAN_BLU: begin
        red_next = comp_data.p;   green_next = comp_data.q;   blue_next = comp_data.val;
      end
      SECTOR_BLU_MAG: begin
        red_next = comp_data.t;   green_next = comp_data.p;   blue_next = comp_data.val;
      end
      default: begin
        red_next = comp_data.val; green_next = comp_data.p;   blue_next = comp_data.q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= comp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && comp_valid) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid && !comp_valid)
    else $error("pipeline valid bits survive reset");

  a_comp_bounded: assert property (@(posedge clk) disable iff (rst)
    comp_valid |-> (comp_data.p <= comp_data.val) && (comp_data.q <= comp_data.val)
                   && (comp_data.t <= comp_data.val))
    else $error("scaled component exceeds brightness");

  a_comp_holds: assert property (@(posedge clk) disable iff (rst)
    comp_valid && !adv_out |=> comp_valid && $stable(comp_data))
    else $error("held beat in scale stage changed or dropped");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && comp_valid && coef_valid && split_valid |-> in_stall)
    else $error("input accepted while pipeline is full and stalled");
`endif

endmodule

@@ test/hsv_to_rgb_checker.sv @@
`timescale 1ns / 1ps

module hsv_to_rgb_checker
  import h2r_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] hue,
  input  logic [16:0] saturation,
  input  logic [16:0] brightness,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [16:0] red,
  input  logic [16:0] green,
  input  logic [16:0] blue,
  output int          errors,
  output int          pending
);

  localparam logic [18:0] SECTORS_PER_TURN = 19'd6;

  typedef struct packed {
    logic [16:0] red;
    logic [16:0] green;
    logic [16:0] blue;
  } rgb_t;

  rgb_t rgb_due[$];

  // a*b in Q16, rounded half up
  function automatic logic [16:0] q16_scale(input logic [16:0] a, input logic [16:0] b);
    logic [34:0] prod;
    prod = ({18'd0, a} * {18'd0, b}) + 35'd32768;
    return prod[32:16];
  endfunction

  function automatic rgb_t rgb_from_hsv(input logic [15:0] h, input logic [16:0] s_raw,
                                        input logic [16:0] v);
    logic [16:0] s;
    logic [18:0] h6;
    logic [16:0] f;
    logic [16:0] p;
    logic [16:0] q;
    logic [16:0] t;
    rgb_t c;
    s = (s_raw > ONE_Q16) ? ONE_Q16 : s_raw;
    if (s == 17'd0) begin
      c = '{red: v, green: v, blue: v};
    end else begin
      h6 = {3'd0, h} * SECTORS_PER_TURN;
      f  = {1'b0, h6[15:0]};
      p  = q16_scale(v, ONE_Q16 - s);
      q  = q16_scale(v, ONE_Q16 - q16_scale(s, f));
      t  = q16_scale(v, ONE_Q16 - q16_scale(s, ONE_Q16 - f));
      case (h6[18:16])
        SECTOR_RED_YEL:  c = '{red: v, green: t, blue: p};
        SECTOR_YEL_GRN:  c = '{red: q, green: v, blue: p};
        SECTOR_GRN_CYAN: c = '{red: p, green: v, blue: t};
        SECTOR_CYAN_BLU: c = '{red: p, green: q, blue: v};
        SECTOR_BLU_MAG:  c = '{red: t, green: p, blue: v};
        default:         c = '{red: v, green: p, blue: q};
      endcase
    end
    return c;
  endfunction

  always @(posedge clk) begin
    int   bad;
    int   delta;
    rgb_t want;
    bad   = 0;
    delta = 0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        rgb_due.push_back(rgb_from_hsv(hue, saturation, brightness));
        delta++;
      end
      if (out_valid && !out_stall) begin
        if (rgb_due.size() == 0) begin
          $display("%0t: output beat with nothing expected: actual r=%0d g=%0d b=%0d",
                   $time, red, green, blue);
          bad++;
        end else begin
          want = rgb_due.pop_front();
          delta--;
          if (red !== want.red) begin
            $display("%0t: red mismatch: expected %0d actual %0d", $time, want.red, red);
            bad++;
          end
          if (green !== want.green) begin
            $display("%0t: green mismatch: expected %0d actual %0d", $time, want.green, green);
            bad++;
          end
          if (blue !== want.blue) begin
            $display("%0t: blue mismatch: expected %0d actual %0d", $time, want.blue, blue);
            bad++;
          end
        end
      end
    end
    if (rst) begin
      errors  <= 0;
      pending <= 0;
    end else begin
      errors  <= errors + bad;
      pending <= pending + delta;
    end
  end

endmodule

@@ test/hsv_to_rgb_converter_test.sv @@
`timescale 1ns / 1ps

module hsv_to_rgb_converter_test;

  localparam int RANDOM_BEATS = 1450;
  localparam int QUIET_BEATS  = 150;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 12;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] hue;
  logic [16:0] saturation;
  logic [16:0] brightness;
  logic        out_valid;
  logic        out_stall;
  logic [16:0] red;
  logic [16:0] green;
  logic [16:0] blue;

  int errors;
  int pending;
  bit quiet;

  hsv_to_rgb_converter uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  hsv_to_rgb_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one color and hold it until the block takes it
  task automatic send_hsv(input logic [15:0] h, input logic [16:0] s, input logic [16:0] v);
    in_valid   <= 1'b1;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random_hsv();
    logic [15:0] h;
    logic [16:0] s;
    logic [16:0] v;
    // bias some hues onto the sector boundaries
    if ($urandom_range(0, 4) == 0)
      h = 16'(($urandom_range(0, 5) * 65536 + 5) / 6 + $urandom_range(0, 2) - 1);
    else
      h = 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 9))
      0:       s = 17'd0;
      1:       s = 17'd65536;
      2:       s = 17'($urandom_range(65537, 131071));
      3:       s = 17'($urandom_range(1, 255));
      default: s = 17'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(0, 7))
      0:       v = 17'd65536;
      1:       v = 17'($urandom_range(65537, 131071));
      2:       v = 17'd0;
      default: v = 17'($urandom_range(0, 65535));
    endcase
    send_hsv(h, s, v);
  endtask

  initial begin
    in_valid   <= 1'b0;
    hue        <= '0;
    saturation <= '0;
    brightness <= '0;
    quiet      = 1'b0;
    rst        <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // grey, clamp and range corners
    send_hsv(16'd0,     17'd0,      17'd65536);
    send_hsv(16'd40000, 17'd0,      17'd131071);
    send_hsv(16'd65535, 17'd0,      17'd0);
    send_hsv(16'd0,     17'd65536,  17'd65536);
    send_hsv(16'd65535, 17'd65536,  17'd65536);
    send_hsv(16'd12345, 17'd131071, 17'd65536);
    send_hsv(16'd30000, 17'd65537,  17'd131071);
    send_hsv(16'd50000, 17'd1,      17'd65536);
    send_hsv(16'd20000, 17'd65535,  17'd1);
    send_hsv(16'd5000,  17'd32768,  17'd0);
    // both sides of every sector boundary
    send_hsv(16'd10922, 17'd65536,  17'd65536);
    send_hsv(16'd10923, 17'd65536,  17'd65536);
    send_hsv(16'd21845, 17'd40000,  17'd60000);
    send_hsv(16'd21846, 17'd40000,  17'd60000);
    send_hsv(16'd32767, 17'd65536,  17'd131071);
    send_hsv(16'd32768, 17'd65536,  17'd131071);
    send_hsv(16'd43690, 17'd20000,  17'd65536);
    send_hsv(16'd43691, 17'd20000,  17'd65536);
    send_hsv(16'd54613, 17'd65536,  17'd98304);
    send_hsv(16'd54614, 17'd65536,  17'd98304);
    send_hsv(16'd65535, 17'd50000,  17'd131071);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == RANDOM_BEATS - QUIET_BEATS)
        quiet = 1'b1;
      if (!quiet && $urandom_range(0, 4) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      send_random_hsv();
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Output backpressure in random bursts, off for the tail of the run
  initial begin
    out_stall <= 1'b0;
    @(negedge rst);
    while (!quiet) begin
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
